// ===== src/clps_pkg.sv =====
// Shared constants and types for the closest polyline segment core.
`default_nettype none
package clps_pkg;

  localparam int MaxPoints = 256;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = AddrW + 1;
  localparam int CoordW    = 20;
  localparam int VertW     = 3 * CoordW;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 9;

  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLOSED_LOOP = 2'd1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD0  = 10'b00_0000_0010,
    S_RDJ  = 10'b00_0000_0100,
    S_MUL  = 10'b00_0000_1000,
    S_TSEL = 10'b00_0001_0000,
    S_DIV  = 10'b00_0010_0000,
    S_DT   = 10'b00_0100_0000,
    S_SQ   = 10'b00_1000_0000,
    S_CMP  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_e;

endpackage
`default_nettype wire

// ===== src/closest_polyline_segment_core.sv =====
// Closest polyline edge search: vertex store, sequencer and shared multiplier.
`default_nettype none
// Load requests (kind 0) write one vertex and finish in the cycle they are taken. A query
// request walks every edge once and raises done_o for exactly one cycle with the winning
// edge; busy is high from the query until that cycle. An edge whose projection falls strictly
// inside it needs the 16-step radix-2 divider; the rest of the edge work is issued one
// product per cycle through a single 22x22 multiplier, and vertices come from a one-port
// store read once per edge, plus once for the first vertex. The receiver cannot
// stall; a result must be taken in its cycle.
module closest_polyline_segment_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind_i,
  input  wire logic [7:0]                    vertex_index_i,
  input  wire logic signed [19:0]            pos_x_i,
  input  wire logic signed [19:0]            pos_y_i,
  input  wire logic signed [19:0]            pos_z_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [clps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [clps_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                               done_o,
  output logic [7:0]                         edge_index_o,
  output logic [16:0]                        edge_alpha_o,
  output logic [59:0]                        distance_squared_o
);
  import clps_pkg::*;

  state_e state_q, state_d;

  logic [CountW-1:0] pc_q;
  logic              closed_q;
  logic [CountW-1:0] n_eff, edges;

  logic [VertW-1:0] mem [MaxPoints];
  logic [VertW-1:0] rd_q, cur_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  logic [3:0]        k_q;
  logic [AddrW-1:0]  i_q, ip1, j_cur, j_next;
  logic              last_edge;
  logic signed [19:0] px_q, py_q, pz_q;
  logic signed [20:0] dx_q, dy_q, dz_q, wx_q, wy_q, wz_q;
  logic signed [43:0] len2_q, dot_q;
  logic [43:0]        rem_q;
  logic [44:0]        rem_sh;
  logic               rem_ge;
  logic [16:0]        t_q;
  logic [36:0]        m0_q, m1_q, m2_q;
  logic [77:0]        acc_q;
  logic [61:0]        edge_dist;
  logic [5:0]         tag_q, tag_d;

  logic signed [21:0] mul_a, mul_b;
  logic signed [43:0] p_q;

  logic signed [20:0] w_sel;
  logic signed [38:0] e_val;
  logic [36:0]        m_val;

  logic [7:0]  best_edge_q;
  logic [16:0] best_t_q;
  logic [61:0] best_d_q;
  logic        first_q;

  logic accept, q_start;

  assign accept      = start && !busy;
  assign q_start     = accept && (kind_i == KIND_QUERY);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign n_eff = (pc_q > CountW'(MaxPoints)) ? CountW'(MaxPoints) : pc_q;
  assign edges = (n_eff < CountW'(2)) ? '0 : (closed_q ? n_eff : n_eff - CountW'(1));

  assign ip1       = i_q + AddrW'(1);
  assign j_cur     = ({1'b0, i_q} + CountW'(1) == n_eff) ? '0 : ip1;
  assign j_next    = ({1'b0, ip1} + CountW'(1) == n_eff) ? '0 : ip1 + AddrW'(1);
  assign last_edge = ({1'b0, i_q} == edges - CountW'(1));

  // divider step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, len2_q});

  assign edge_dist = acc_q[77:16];

  // error term of one component, then its magnitude (|e| < 2^37)
  always_comb begin
    case (tag_q[1:0])
      2'd0:    w_sel = wx_q;
      2'd1:    w_sel = wy_q;
      2'd2:    w_sel = wz_q;
      default: w_sel = '0;
    endcase
    e_val = $signed({{2{w_sel[20]}}, w_sel, 16'b0}) - p_q[38:0];
    m_val = e_val[38] ? 37'(-e_val) : e_val[36:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    tag_d = '0;
    case (state_q)
      S_MUL: begin
        case (k_q)
          4'd0: begin mul_a = 22'(dx_q); mul_b = 22'(dx_q); end
          4'd1: begin mul_a = 22'(dy_q); mul_b = 22'(dy_q); end
          4'd2: begin mul_a = 22'(dz_q); mul_b = 22'(dz_q); end
          4'd3: begin mul_a = 22'(wx_q); mul_b = 22'(dx_q); tag_d = 6'd1; end
          4'd4: begin mul_a = 22'(wy_q); mul_b = 22'(dy_q); tag_d = 6'd1; end
          4'd5: begin mul_a = 22'(wz_q); mul_b = 22'(dz_q); tag_d = 6'd1; end
          default: ;
        endcase
      end
      S_DT: begin
        mul_b = $signed({5'b0, t_q});
        case (k_q)
          4'd0: mul_a = 22'(dx_q);
          4'd1: begin mul_a = 22'(dy_q); tag_d = 6'd1; end
          4'd2: begin mul_a = 22'(dz_q); tag_d = 6'd2; end
          default: ;
        endcase
      end
      S_SQ: begin
        // m^2 = hi^2 << 38 + 2*hi*lo << 19 + lo^2
        case (k_q)
          4'd0: begin
            mul_a = $signed({4'b0, m0_q[36:19]}); mul_b = mul_a; tag_d = 6'd38;
          end
          4'd1: begin
            mul_a = $signed({4'b0, m0_q[36:19]}); mul_b = $signed({3'b0, m0_q[18:0]});
            tag_d = 6'd20;
          end
          4'd2: begin
            mul_a = $signed({3'b0, m0_q[18:0]}); mul_b = mul_a;
          end
          4'd3: begin
            mul_a = $signed({4'b0, m1_q[36:19]}); mul_b = mul_a; tag_d = 6'd38;
          end
          4'd4: begin
            mul_a = $signed({4'b0, m1_q[36:19]}); mul_b = $signed({3'b0, m1_q[18:0]});
            tag_d = 6'd20;
          end
          4'd5: begin
            mul_a = $signed({3'b0, m1_q[18:0]}); mul_b = mul_a;
          end
          4'd6: begin
            mul_a = $signed({4'b0, m2_q[36:19]}); mul_b = mul_a; tag_d = 6'd38;
          end
          4'd7: begin
            mul_a = $signed({4'b0, m2_q[36:19]}); mul_b = $signed({3'b0, m2_q[18:0]});
            tag_d = 6'd20;
          end
          4'd8: begin
            mul_a = $signed({3'b0, m2_q[18:0]}); mul_b = mul_a;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        if (q_start) begin
          if (edges == '0) begin
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        rd_en   = 1'b1;
        rd_addr = j_cur;
        state_d = S_RDJ;
      end
      S_RDJ:  state_d = S_MUL;
      S_MUL:  if (k_q == 4'd6) state_d = S_TSEL;
      S_TSEL: begin
        if (len2_q == '0 || dot_q <= 0 || dot_q >= len2_q) state_d = S_DT;
        else state_d = S_DIV;
      end
      S_DIV:  if (k_q == 4'd15) state_d = S_DT;
      S_DT:   if (k_q == 4'd3) state_d = S_SQ;
      S_SQ:   if (k_q == 4'd9) state_d = S_CMP;
      S_CMP: begin
        if (last_edge) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_next;
          state_d = S_RDJ;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      closed_q <= 1'b0;
      k_q      <= '0;
      i_q      <= '0;
      first_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POINT_COUNT) pc_q <= cfg_data_i;
        else if (cfg_index_i == CFG_CLOSED_LOOP) closed_q <= cfg_data_i[0];
      end
      if (state_q != state_d) k_q <= '0;
      else k_q <= k_q + 4'd1;
      if (q_start) begin
        i_q     <= '0;
        first_q <= 1'b1;
      end else if (state_q == S_CMP) begin
        first_q <= 1'b0;
        i_q     <= ip1;
      end
    end
  end

  // vertex store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_LOAD) mem[vertex_index_i] <= {pos_x_i, pos_y_i, pos_z_i};
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    p_q   <= mul_a * mul_b;
    tag_q <= tag_d;
    if (q_start) begin
      px_q        <= pos_x_i;
      py_q        <= pos_y_i;
      pz_q        <= pos_z_i;
      best_edge_q <= '0;
      best_t_q    <= '0;
      best_d_q    <= '0;
    end
    case (state_q)
      S_RD0: cur_q <= rd_q;
      S_RDJ: begin
        dx_q   <= 21'($signed(rd_q[59:40])) - 21'($signed(cur_q[59:40]));
        dy_q   <= 21'($signed(rd_q[39:20])) - 21'($signed(cur_q[39:20]));
        dz_q   <= 21'($signed(rd_q[19:0]))  - 21'($signed(cur_q[19:0]));
        wx_q   <= 21'(px_q) - 21'($signed(cur_q[59:40]));
        wy_q   <= 21'(py_q) - 21'($signed(cur_q[39:20]));
        wz_q   <= 21'(pz_q) - 21'($signed(cur_q[19:0]));
        cur_q  <= rd_q;
        len2_q <= '0;
        dot_q  <= '0;
      end
      S_MUL: begin
        if (k_q != 4'd0) begin
          if (tag_q[0]) dot_q <= dot_q + p_q;
          else len2_q <= len2_q + p_q;
        end
      end
      S_TSEL: begin
        rem_q <= dot_q;
        if (len2_q == '0 || dot_q <= 0) t_q <= '0;
        else if (dot_q >= len2_q) t_q <= 17'h10000;
        else t_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_ge ? 44'(rem_sh - {1'b0, len2_q}) : rem_sh[43:0];
        t_q   <= {t_q[15:0], rem_ge};
      end
      S_DT: begin
        acc_q <= '0;
        if (k_q != 4'd0) begin
          case (tag_q[1:0])
            2'd0:    m0_q <= m_val;
            2'd1:    m1_q <= m_val;
            default: m2_q <= m_val;
          endcase
        end
      end
      S_SQ: begin
        if (k_q != 4'd0) acc_q <= acc_q + (78'(unsigned'(p_q)) << tag_q);
      end
      S_CMP: begin
        if (first_q || edge_dist < best_d_q) begin
          best_d_q    <= edge_dist;
          best_edge_q <= i_q;
          best_t_q    <= t_q;
        end
      end
      default: ;
    endcase
  end

  assign done_o             = (state_q == S_DONE);
  assign edge_index_o       = best_edge_q;
  assign edge_alpha_o       = best_t_q;
  assign distance_squared_o = best_d_q[59:0];

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (edge_alpha_o <= 17'h10000))
    else $error("edge_alpha out of range");

endmodule
`default_nettype wire

// ===== dv/tb_closest_polyline_segment_core.sv =====
// Self-checking testbench for the closest polyline segment core.
`timescale 1ns / 100ps
module tb_closest_polyline_segment_core;
  import clps_pkg::*;

  typedef struct {
    logic [7:0]  edge_idx;
    logic [16:0] alpha;
    logic [59:0] sq_dist;
  } nearest_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                kind_i = KIND_LOAD;
  logic [7:0]          vertex_index_i = '0;
  logic signed [19:0]  pos_x_i = '0;
  logic signed [19:0]  pos_y_i = '0;
  logic signed [19:0]  pos_z_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_POINT_COUNT;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                done_o;
  logic [7:0]          edge_index_o;
  logic [16:0]         edge_alpha_o;
  logic [59:0]         distance_squared_o;

  closest_polyline_segment_core dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .vertex_index_i, .pos_x_i, .pos_y_i,
    .pos_z_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .done_o,
    .edge_index_o, .edge_alpha_o, .distance_squared_o
  );

  // shadow state
  logic signed [19:0] vert_x [MaxPoints];
  logic signed [19:0] vert_y [MaxPoints];
  logic signed [19:0] vert_z [MaxPoints];
  logic [8:0]         shadow_count = '0;
  logic               shadow_closed = 1'b0;
  nearest_t           pending_nearest [$];
  int                 errors = 0;
  int                 requests_sent = 0;
  int                 queries_sent = 0;
  bit                 gaps_on = 1'b1;
  longint             cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic nearest_t predict_nearest(longint px, longint py, longint pz);
    nearest_t    best;
    int          n, nedges, j;
    longint      dx, dy, dz, wx, wy, wz, len2, dotp, t, e [3];
    logic [127:0] mag, acc, cur_dist, best_dist;
    bit          have;
    best = '{8'd0, 17'd0, 60'd0};
    best_dist = '0;
    have = 0;
    n = (shadow_count > MaxPoints) ? MaxPoints : shadow_count;
    nedges = (n < 2) ? 0 : (shadow_closed ? n : n - 1);
    for (int i = 0; i < nedges; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      dx = longint'(vert_x[j]) - vert_x[i];
      dy = longint'(vert_y[j]) - vert_y[i];
      dz = longint'(vert_z[j]) - vert_z[i];
      wx = px - vert_x[i];
      wy = py - vert_y[i];
      wz = pz - vert_z[i];
      len2 = dx * dx + dy * dy + dz * dz;
      dotp = wx * dx + wy * dy + wz * dz;
      if (len2 == 0 || dotp <= 0) t = 0;
      else if (dotp >= len2) t = 65536;
      else t = (dotp * 65536) / len2;
      e[0] = wx * 65536 - dx * t;
      e[1] = wy * 65536 - dy * t;
      e[2] = wz * 65536 - dz * t;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        mag = (e[k] < 0) ? 128'(-e[k]) : 128'(e[k]);
        acc += mag * mag;
      end
      cur_dist = acc >> 16;
      if (!have || cur_dist < best_dist) begin
        have = 1;
        best_dist = cur_dist;
        best.edge_idx = i[7:0];
        best.alpha = t[16:0];
        best.sq_dist = cur_dist[59:0];
      end
    end
    return best;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    nearest_t want;
    if (rst_ni && done_o) begin
      if (pending_nearest.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result edge %0d", edge_index_o);
      end else begin
        want = pending_nearest.pop_front();
        if (edge_index_o !== want.edge_idx || edge_alpha_o !== want.alpha ||
            distance_squared_o !== want.sq_dist) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp edge %0d alpha %0d dist %0d, got edge %0d alpha %0d dist %0d",
                     want.edge_idx, want.alpha, want.sq_dist,
                     edge_index_o, edge_alpha_o, distance_squared_o);
        end
      end
    end
  end

  task automatic send_request(logic kind, logic [7:0] slot, logic signed [19:0] x,
                              logic signed [19:0] y, logic signed [19:0] z);
    kind_i <= kind;
    vertex_index_i <= slot;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
    if (kind == KIND_LOAD) begin
      vert_x[slot] = x;
      vert_y[slot] = y;
      vert_z[slot] = z;
    end else begin
      queries_sent++;
      pending_nearest.push_back(predict_nearest(x, y, z));
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // loads complete at once, so a short pause after the last result is enough
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_POINT_COUNT) shadow_count = data;
    else if (idx == CFG_CLOSED_LOOP) shadow_closed = data[0];
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [19:0] rand_coord(bit near);
    if (near) return 20'(int'($urandom_range(0, 64)) - 32);
    return 20'($urandom);
  endfunction

  task automatic load_path(int n, bit near);
    for (int i = 0; i < n; i++)
      send_request(KIND_LOAD, i[7:0], rand_coord(near), rand_coord(near), rand_coord(near));
  endtask

  task automatic test_short_paths();
    write_reg(CFG_POINT_COUNT, 9'd0);
    write_reg(CFG_CLOSED_LOOP, 9'd1);
    send_request(KIND_QUERY, 8'd0, 20'sh7FFFF, 20'sh80000, 20'sd0);
    send_request(KIND_LOAD, 8'd0, 20'sd5, -20'sd5, 20'sd1);
    wait_idle();
    write_reg(CFG_POINT_COUNT, 9'd1);
    send_request(KIND_QUERY, 8'd0, 20'sh80000, 20'sh7FFFF, -20'sd1);
    wait_idle();
  endtask

  task automatic test_special_edges();
    // extreme corners, a degenerate edge, and a square that makes ties
    send_request(KIND_LOAD, 8'd0, 20'sh80000, 20'sh80000, 20'sh80000);
    send_request(KIND_LOAD, 8'd1, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_request(KIND_LOAD, 8'd2, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_request(KIND_LOAD, 8'd3, 20'sh7FFFF, 20'sh80000, 20'sd0);
    wait_idle();
    write_reg(CFG_POINT_COUNT, 9'd4);
    write_reg(CFG_CLOSED_LOOP, 9'd0);
    send_request(KIND_QUERY, 8'd0, 20'sh80000, 20'sh80000, 20'sh80000);
    send_request(KIND_QUERY, 8'd0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_request(KIND_QUERY, 8'd0, 20'sd0, 20'sd0, 20'sd0);
    send_request(KIND_QUERY, 8'd0, 20'sd12345, -20'sd777, 20'sd3);
    wait_idle();
    write_reg(CFG_CLOSED_LOOP, 9'd1);
    send_request(KIND_QUERY, 8'd0, 20'sd0, 20'sh80000, 20'sh80000);
    send_request(KIND_LOAD, 8'd0, 20'sd0, 20'sd0, 20'sd0);
    send_request(KIND_LOAD, 8'd1, 20'sd10, 20'sd0, 20'sd0);
    send_request(KIND_LOAD, 8'd2, 20'sd10, 20'sd10, 20'sd0);
    send_request(KIND_LOAD, 8'd3, 20'sd0, 20'sd10, 20'sd0);
    send_request(KIND_QUERY, 8'd0, 20'sd5, 20'sd5, 20'sd0);
    send_request(KIND_QUERY, 8'd0, 20'sd3, 20'sd7, -20'sd4);
    send_request(KIND_QUERY, 8'd0, -20'sd3, 20'sd4, 20'sd0);
    wait_idle();
  endtask

  task automatic test_full_store();
    load_path(MaxPoints, 1'b0);
    wait_idle();
    write_reg(CFG_POINT_COUNT, 9'd256);
    write_reg(CFG_CLOSED_LOOP, 9'd0);
    send_request(KIND_QUERY, 8'd0, rand_coord(0), rand_coord(0), rand_coord(0));
    wait_idle();
    write_reg(CFG_POINT_COUNT, 9'd511);  // saturates to the full store
    write_reg(CFG_CLOSED_LOOP, 9'd1);
    send_request(KIND_QUERY, 8'd0, vert_x[255], vert_y[255], vert_z[255]);
    send_request(KIND_QUERY, 8'd0, rand_coord(0), rand_coord(0), rand_coord(0));
    wait_idle();
  endtask

  task automatic test_random_paths();
    int  n;
    bit  near;
    while (requests_sent < 140 + MaxPoints || queries_sent < 50) begin
      if (requests_sent > 100 + MaxPoints) gaps_on = 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 10);
      near = $urandom_range(0, 1);
      wait_idle();
      write_reg(CFG_POINT_COUNT, 9'(n));
      write_reg(CFG_CLOSED_LOOP, 9'($urandom_range(0, 1)));
      load_path(n, near);
      repeat ($urandom_range(2, 5)) begin
        // occasional rewrite of a live slot between queries
        if (n > 0 && $urandom_range(0, 4) == 0)
          send_request(KIND_LOAD, 8'($urandom_range(0, n - 1)), rand_coord(near),
                       rand_coord(near), rand_coord(near));
        send_request(KIND_QUERY, 8'($urandom), rand_coord(near), rand_coord(near),
                     rand_coord(near));
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < MaxPoints; i++) begin
      vert_x[i] = '0;
      vert_y[i] = '0;
      vert_z[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_paths();
    test_special_edges();
    test_full_store();
    test_random_paths();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_nearest.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== closest_polyline_segment_core.f =====
src/clps_pkg.sv
src/closest_polyline_segment_core.sv
dv/tb_closest_polyline_segment_core.sv
